[hw/rtl/tis_pkg.sv]
// Package for the three-wide issue select block: descriptor layout, types,
// decode, clash and issue-step functions. Depends on nothing.
`timescale 1ns / 1ps

package tis_pkg;

   localparam int QUEUE_DEPTH    = 8;
   localparam int ROB_DEPTH      = 32;
   localparam int REG_INDEX_BITS = 5;

   localparam int INSTR_BITS = 34;
   localparam int QFREE_BITS = 4;
   localparam int RFREE_BITS = 6;
   localparam int COUNT_BITS = 2;
   localparam int SLOT_BITS  = 2;

   localparam int REQ_DATA_BITS = 120;
   localparam int RSP_DATA_BITS = 24;

   localparam int BIT_ILLEGAL = 0;
   localparam int BIT_MEM     = 1;
   localparam int BIT_FPU     = 2;
   localparam int BIT_USE1    = 3;
   localparam int BIT_USE2    = 4;
   localparam int BIT_USE3    = 5;
   localparam int BIT_RS1_FP  = 6;
   localparam int BIT_RS2_FP  = 7;
   localparam int BIT_RD_FP   = 8;
   localparam int RS1_POS     = 10;
   localparam int RS2_POS     = RS1_POS + REG_INDEX_BITS;
   localparam int RS3_POS     = RS2_POS + REG_INDEX_BITS;
   localparam int RD_POS      = RS3_POS + REG_INDEX_BITS;

   localparam logic [SLOT_BITS-1:0] SLOT_FROM_DECODE = 2'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_FROM_FIRST  = 2'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_FROM_SECOND = 2'd2;
   localparam logic [SLOT_BITS-1:0] SLOT_FROM_THIRD  = 2'd3;

   typedef logic [REG_INDEX_BITS-1:0] reg_index_type;

   typedef struct packed {
      logic          illegal;
      logic          mem;
      logic          fpu;
      logic          use1;
      logic          use2;
      logic          use3;
      logic          rs1_fp;
      logic          rs2_fp;
      logic          rd_fp;
      reg_index_type rs1;
      reg_index_type rs2;
      reg_index_type rs3;
      reg_index_type rd;
   } decoded_type;

   typedef struct packed {
      logic [QFREE_BITS-1:0] alu;
      logic [QFREE_BITS-1:0] fpu;
      logic [QFREE_BITS-1:0] lsu;
      logic [RFREE_BITS-1:0] rob;
      logic [COUNT_BITS-1:0] alu_push;
      logic [COUNT_BITS-1:0] fpu_push;
      logic [COUNT_BITS-1:0] lsu_push;
      logic [COUNT_BITS-1:0] rob_take;
   } pool_type;

   typedef struct packed {
      logic     ok;
      pool_type pool;
   } issue_type;

   function automatic decoded_type unpack(input logic [INSTR_BITS-1:0] w);
      decoded_type d;
      d.illegal = w[BIT_ILLEGAL];
      d.mem     = w[BIT_MEM];
      d.fpu     = w[BIT_FPU];
      d.use1    = w[BIT_USE1];
      d.use2    = w[BIT_USE2];
      d.use3    = w[BIT_USE3];
      d.rs1_fp  = w[BIT_RS1_FP];
      d.rs2_fp  = w[BIT_RS2_FP];
      d.rd_fp   = w[BIT_RD_FP];
      d.rs1     = w[RS1_POS +: REG_INDEX_BITS];
      d.rs2     = w[RS2_POS +: REG_INDEX_BITS];
      d.rs3     = w[RS3_POS +: REG_INDEX_BITS];
      d.rd      = w[RD_POS +: REG_INDEX_BITS];
      return d;
   endfunction

   // True when the younger instruction reads a register that the older one writes.
   function automatic logic clashes(input decoded_type old_i, input decoded_type young_i);
      logic c1;
      logic c2;
      logic c3;
      c1 = young_i.use1 && (young_i.rs1 == old_i.rd) && (young_i.rs1_fp == old_i.rd_fp)
           && ((young_i.rs1 != '0) || young_i.rs1_fp);
      c2 = young_i.use2 && (young_i.rs2 == old_i.rd) && (young_i.rs2_fp == old_i.rd_fp)
           && ((young_i.rs2 != '0) || young_i.rs2_fp);
      c3 = young_i.use3 && (young_i.rs3 == old_i.rd) && old_i.rd_fp;
      return c1 || c2 || c3;
   endfunction

   function automatic logic [QFREE_BITS-1:0] clamp_queue(input logic [QFREE_BITS-1:0] v);
      return (int'(v) > QUEUE_DEPTH) ? QFREE_BITS'(QUEUE_DEPTH) : v;
   endfunction

   function automatic logic [RFREE_BITS-1:0] clamp_rob(input logic [RFREE_BITS-1:0] v);
      return (int'(v) > ROB_DEPTH) ? RFREE_BITS'(ROB_DEPTH) : v;
   endfunction

   // One issue attempt against the running free counts.
   function automatic issue_type issue_step(input pool_type p, input decoded_type d);
      issue_type r;
      r.pool = p;
      r.ok   = 1'b0;
      if (d.illegal) begin
         r.ok = 1'b1;
      end else if (p.rob != '0) begin
         if (d.mem) begin
            if (p.lsu != '0) begin
               r.ok            = 1'b1;
               r.pool.lsu      = p.lsu - 1'b1;
               r.pool.lsu_push = p.lsu_push + 1'b1;
            end
         end else if (d.fpu) begin
            if (p.fpu != '0) begin
               r.ok            = 1'b1;
               r.pool.fpu      = p.fpu - 1'b1;
               r.pool.fpu_push = p.fpu_push + 1'b1;
            end
         end else begin
            if (p.alu != '0) begin
               r.ok            = 1'b1;
               r.pool.alu      = p.alu - 1'b1;
               r.pool.alu_push = p.alu_push + 1'b1;
            end
         end
         if (r.ok) begin
            r.pool.rob      = p.rob - 1'b1;
            r.pool.rob_take = p.rob_take + 1'b1;
         end
      end
      return r;
   endfunction

endpackage

[hw/rtl/triple_issue_select.sv]
// Issue-group selection for a three-wide core: input register, selection logic,
// result register. Depends on tis_pkg.
// A request goes through the input register, then the result register.
// Throughput: one request per cycle; req_tready follows rsp_tready through the
// two registers, so a stalled result holds the input register as well.
// Reset clears both valid flags; payload registers are not reset.
`timescale 1ns / 1ps

module triple_issue_select (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // oldest_instr, middle_instr, youngest_instr, alu_free, fpu_free, lsu_free, rob_free
   input  logic [tis_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // issued_mask, issued_count, rob_taken, alu_pushes, fpu_pushes, lsu_pushes,
   // slot1_source, slot2_source, zero fill
   output logic [tis_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import tis_pkg::*;

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [REQ_DATA_BITS-1:0] in_data_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff;
   logic [RSP_DATA_BITS-1:0] out_data_in;
   logic                     out_load;

   decoded_type           instr_a;
   decoded_type           instr_b;
   decoded_type           instr_c;
   pool_type              pool0;
   issue_type             step_a;
   issue_type             step_b;
   issue_type             step_c;
   logic                  iss1;
   logic                  iss2;
   logic                  iss3;
   logic [2:0]            mask;
   logic [COUNT_BITS-1:0] count;
   logic [SLOT_BITS-1:0]  slot1;
   logic [SLOT_BITS-1:0]  slot2;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_load;

   always_comb begin
      instr_a = unpack(in_data_ff[33:0]);
      instr_b = unpack(in_data_ff[67:34]);
      instr_c = unpack(in_data_ff[101:68]);

      pool0.alu      = clamp_queue(in_data_ff[105:102]);
      pool0.fpu      = clamp_queue(in_data_ff[109:106]);
      pool0.lsu      = clamp_queue(in_data_ff[113:110]);
      pool0.rob      = clamp_rob(in_data_ff[119:114]);
      pool0.alu_push = '0;
      pool0.fpu_push = '0;
      pool0.lsu_push = '0;
      pool0.rob_take = '0;

      step_a = issue_step(pool0, instr_a);
      iss1   = step_a.ok;
      step_b = issue_step(step_a.pool, instr_b);
      iss2   = (iss1 || !clashes(instr_a, instr_b)) && step_b.ok;
      if (!iss2) begin
         step_b.pool = step_a.pool;
      end
      step_c = issue_step(step_b.pool, instr_c);
      iss3   = (iss1 || !clashes(instr_a, instr_c)) && (iss2 || !clashes(instr_b, instr_c))
               && step_c.ok;
      if (!iss3) begin
         step_c.pool = step_b.pool;
      end

      mask  = {iss3, iss2, iss1};
      count = COUNT_BITS'({1'b0, iss1} + {1'b0, iss2} + {1'b0, iss3});

      slot1 = SLOT_FROM_DECODE;
      slot2 = SLOT_FROM_DECODE;
      if (!iss1) begin
         slot1 = SLOT_FROM_FIRST;
      end
      if (!iss2) begin
         if (slot1 == SLOT_FROM_DECODE) begin
            slot1 = SLOT_FROM_SECOND;
         end else begin
            slot2 = SLOT_FROM_SECOND;
         end
      end
      if (!iss3) begin
         if (slot1 == SLOT_FROM_DECODE) begin
            slot1 = SLOT_FROM_THIRD;
         end else if (slot2 == SLOT_FROM_DECODE) begin
            slot2 = SLOT_FROM_THIRD;
         end
      end

      out_data_in = {7'd0, slot2, slot1, step_c.pool.lsu_push, step_c.pool.fpu_push,
                     step_c.pool.alu_push, step_c.pool.rob_take, count, mask};
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
      if (out_load && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[hw/rtl/tis_checker.sv]
// Port-level checks for triple_issue_select and the bind that attaches them.
// Depends on tis_pkg and triple_issue_select.
`timescale 1ns / 1ps

module tis_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [tis_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tis_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import tis_pkg::*;

   // A stalled result keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // The removed count matches the mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:3] == 2'($countones(rsp_tdata[2:0])))
      else $error("issued count does not match mask");

   // Every reorder-buffer entry goes with exactly one queue push.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {2'b00, rsp_tdata[6:5]} ==
         {2'b00, rsp_tdata[8:7]} + {2'b00, rsp_tdata[10:9]} + {2'b00, rsp_tdata[12:11]})
      else $error("rob entries do not match queue pushes");

   // With an empty pipeline and a free output, a request is taken at once.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!req_tvalid) && !$past(reset) |-> req_tready)
      else $error("request refused with the pipeline empty");

endmodule

bind triple_issue_select tis_checker u_tis_checker (.*);

[bench/triple_issue_select_tb.sv]
// Self-checking testbench for the three-wide issue select block: a directed
// table of issue groups, then biased random groups under varying stalls.
// Depends on tis_pkg and triple_issue_select.
`timescale 1ns / 1ps

module triple_issue_select_tb;

   import tis_pkg::*;

   localparam int INSTR_W   = INSTR_BITS;
   localparam int ALU_LSB   = 3 * INSTR_W;
   localparam int FPU_LSB   = ALU_LSB + QFREE_BITS;
   localparam int LSU_LSB   = FPU_LSB + QFREE_BITS;
   localparam int ROB_LSB   = LSU_LSB + QFREE_BITS;
   localparam int SPARE_BIT = 9;
   localparam int PHASE_ITEMS = 190;
   localparam int REPORT_LIMIT = 10;

   localparam logic [INSTR_W-1:0] FL_ILLEGAL = INSTR_W'(1) << BIT_ILLEGAL;
   localparam logic [INSTR_W-1:0] FL_MEM     = INSTR_W'(1) << BIT_MEM;
   localparam logic [INSTR_W-1:0] FL_FPU     = INSTR_W'(1) << BIT_FPU;
   localparam logic [INSTR_W-1:0] FL_USE1    = INSTR_W'(1) << BIT_USE1;
   localparam logic [INSTR_W-1:0] FL_USE2    = INSTR_W'(1) << BIT_USE2;
   localparam logic [INSTR_W-1:0] FL_USE3    = INSTR_W'(1) << BIT_USE3;
   localparam logic [INSTR_W-1:0] FL_RS1_FP  = INSTR_W'(1) << BIT_RS1_FP;
   localparam logic [INSTR_W-1:0] FL_RD_FP   = INSTR_W'(1) << BIT_RD_FP;
   localparam logic [INSTR_W-1:0] FL_SPARE   = INSTR_W'(1) << SPARE_BIT;
   localparam logic [INSTR_W-1:0] FL_HIGH    = {4'hF, 30'd0};
   localparam logic [INSTR_W-1:0] PLAIN_ALU  = '0;

   typedef enum int {UNIT_ALU, UNIT_FPU, UNIT_LSU} unit_type;

   typedef struct packed {
      logic          illegal;
      logic          mem;
      logic          fpu;
      logic          use1;
      logic          use2;
      logic          use3;
      logic          rs1_fp;
      logic          rs2_fp;
      logic          rd_fp;
      reg_index_type rs1;
      reg_index_type rs2;
      reg_index_type rs3;
      reg_index_type rd;
   } instr_fields_type;

   typedef struct packed {
      logic [2:0]            mask;
      logic [COUNT_BITS-1:0] count;
      logic [COUNT_BITS-1:0] rob_taken;
      logic [COUNT_BITS-1:0] alu_pushes;
      logic [COUNT_BITS-1:0] fpu_pushes;
      logic [COUNT_BITS-1:0] lsu_pushes;
      logic [SLOT_BITS-1:0]  slot1;
      logic [SLOT_BITS-1:0]  slot2;
   } issue_outcome_type;

   typedef struct {
      logic [REQ_DATA_BITS-1:0] word;
      bit                       typed;
      issue_outcome_type        outcome;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   issue_outcome_type pending_groups[$];
   stim_row_type      stim_rows[$];
   int unsigned       fail_count = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_stall_pct = 0;

   triple_issue_select u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic instr_fields_type split_instr(input logic [INSTR_W-1:0] w);
      instr_fields_type f;
      f.illegal = w[BIT_ILLEGAL];
      f.mem     = w[BIT_MEM];
      f.fpu     = w[BIT_FPU];
      f.use1    = w[BIT_USE1];
      f.use2    = w[BIT_USE2];
      f.use3    = w[BIT_USE3];
      f.rs1_fp  = w[BIT_RS1_FP];
      f.rs2_fp  = w[BIT_RS2_FP];
      f.rd_fp   = w[BIT_RD_FP];
      f.rs1     = w[RS1_POS +: REG_INDEX_BITS];
      f.rs2     = w[RS2_POS +: REG_INDEX_BITS];
      f.rs3     = w[RS3_POS +: REG_INDEX_BITS];
      f.rd      = w[RD_POS +: REG_INDEX_BITS];
      return f;
   endfunction

   // The integer zero register is never a real dependency.
   function automatic bit writes_reg(input instr_fields_type older, input logic in_fp,
                                     input reg_index_type idx);
      return (idx == older.rd) && (in_fp == older.rd_fp) && (in_fp || idx != '0);
   endfunction

   function automatic bit depends_on(input instr_fields_type older,
                                     input instr_fields_type younger);
      return (younger.use1 && writes_reg(older, younger.rs1_fp, younger.rs1))
          || (younger.use2 && writes_reg(older, younger.rs2_fp, younger.rs2))
          || (younger.use3 && writes_reg(older, 1'b1, younger.rs3));
   endfunction

   function automatic int unsigned clamp_free(input int unsigned v, input int unsigned depth);
      return (v > depth) ? depth : v;
   endfunction

   function automatic issue_outcome_type select_issue_group(
         input logic [REQ_DATA_BITS-1:0] word);
      instr_fields_type  grp [3];
      int unsigned       room [3];
      int unsigned       pushes [3];
      int unsigned       rob_room;
      int unsigned       rob_used;
      int unsigned       filled;
      logic [2:0]        took;
      bit                blocked;
      unit_type          unit;
      issue_outcome_type res;
      for (int k = 0; k < 3; k++) begin
         grp[k] = split_instr(word[k*INSTR_W +: INSTR_W]);
         pushes[k] = 0;
      end
      room[UNIT_ALU] = clamp_free(32'(word[ALU_LSB +: QFREE_BITS]), QUEUE_DEPTH);
      room[UNIT_FPU] = clamp_free(32'(word[FPU_LSB +: QFREE_BITS]), QUEUE_DEPTH);
      room[UNIT_LSU] = clamp_free(32'(word[LSU_LSB +: QFREE_BITS]), QUEUE_DEPTH);
      rob_room = clamp_free(32'(word[ROB_LSB +: RFREE_BITS]), ROB_DEPTH);
      rob_used = 0;
      took = '0;
      for (int k = 0; k < 3; k++) begin
         blocked = 1'b0;
         for (int j = 0; j < k; j++) begin
            if (!took[j] && depends_on(grp[j], grp[k])) begin
               blocked = 1'b1;
            end
         end
         if (!blocked) begin
            if (grp[k].illegal) begin
               took[k] = 1'b1;
            end else begin
               unit = grp[k].mem ? UNIT_LSU : (grp[k].fpu ? UNIT_FPU : UNIT_ALU);
               if (room[unit] != 0 && rob_room != 0) begin
                  room[unit]--;
                  rob_room--;
                  pushes[unit]++;
                  rob_used++;
                  took[k] = 1'b1;
               end
            end
         end
      end
      res.mask       = took;
      res.count      = COUNT_BITS'($countones(took));
      res.rob_taken  = COUNT_BITS'(rob_used);
      res.alu_pushes = COUNT_BITS'(pushes[UNIT_ALU]);
      res.fpu_pushes = COUNT_BITS'(pushes[UNIT_FPU]);
      res.lsu_pushes = COUNT_BITS'(pushes[UNIT_LSU]);
      res.slot1      = SLOT_FROM_DECODE;
      res.slot2      = SLOT_FROM_DECODE;
      filled = 0;
      for (int k = 0; k < 3; k++) begin
         if (!took[k] && filled < 2) begin
            if (filled == 0) begin
               res.slot1 = SLOT_BITS'(k + 1);
            end else begin
               res.slot2 = SLOT_BITS'(k + 1);
            end
            filled++;
         end
      end
      return res;
   endfunction

   function automatic issue_outcome_type split_result(input logic [RSP_DATA_BITS-1:0] d);
      issue_outcome_type r;
      r.mask       = d[2:0];
      r.count      = d[4:3];
      r.rob_taken  = d[6:5];
      r.alu_pushes = d[8:7];
      r.fpu_pushes = d[10:9];
      r.lsu_pushes = d[12:11];
      r.slot1      = d[14:13];
      r.slot2      = d[16:15];
      return r;
   endfunction

   function automatic issue_outcome_type outcome(input int mask, input int count, input int rob,
                                                 input int alu, input int fpu, input int lsu,
                                                 input logic [SLOT_BITS-1:0] s1,
                                                 input logic [SLOT_BITS-1:0] s2);
      issue_outcome_type r;
      r.mask       = 3'(mask);
      r.count      = COUNT_BITS'(count);
      r.rob_taken  = COUNT_BITS'(rob);
      r.alu_pushes = COUNT_BITS'(alu);
      r.fpu_pushes = COUNT_BITS'(fpu);
      r.lsu_pushes = COUNT_BITS'(lsu);
      r.slot1      = s1;
      r.slot2      = s2;
      return r;
   endfunction

   function automatic logic [INSTR_W-1:0] mk_instr(input logic [INSTR_W-1:0] flags,
                                                   input int rs1, input int rs2,
                                                   input int rs3, input int rd);
      logic [INSTR_W-1:0] w;
      w = flags;
      w[RS1_POS +: REG_INDEX_BITS] = REG_INDEX_BITS'(rs1);
      w[RS2_POS +: REG_INDEX_BITS] = REG_INDEX_BITS'(rs2);
      w[RS3_POS +: REG_INDEX_BITS] = REG_INDEX_BITS'(rs3);
      w[RD_POS +: REG_INDEX_BITS]  = REG_INDEX_BITS'(rd);
      return w;
   endfunction

   function automatic logic [REQ_DATA_BITS-1:0] pack_group(
         input logic [INSTR_W-1:0] i1, input logic [INSTR_W-1:0] i2,
         input logic [INSTR_W-1:0] i3, input int alu, input int fpu,
         input int lsu, input int rob);
      return {RFREE_BITS'(rob), QFREE_BITS'(lsu), QFREE_BITS'(fpu), QFREE_BITS'(alu),
              i3, i2, i1};
   endfunction

   task automatic add_row(input logic [REQ_DATA_BITS-1:0] word, input bit typed,
                          input issue_outcome_type o);
      stim_row_type row;
      row.word    = word;
      row.typed   = typed;
      row.outcome = o;
      stim_rows.push_back(row);
   endtask

   // Small register indices keep dependencies between the three slots frequent.
   function automatic logic [INSTR_W-1:0] random_instr();
      logic [INSTR_W-1:0] w;
      w = INSTR_W'({$urandom, $urandom});
      if ($urandom_range(0, 7) != 0) begin
         w[BIT_ILLEGAL] = ($urandom_range(0, 11) == 0);
         if ($urandom_range(0, 4) != 0) begin
            w[RS1_POS +: REG_INDEX_BITS] = REG_INDEX_BITS'($urandom_range(0, 3));
            w[RS2_POS +: REG_INDEX_BITS] = REG_INDEX_BITS'($urandom_range(0, 3));
            w[RS3_POS +: REG_INDEX_BITS] = REG_INDEX_BITS'($urandom_range(0, 3));
            w[RD_POS +: REG_INDEX_BITS]  = REG_INDEX_BITS'($urandom_range(0, 3));
         end
      end
      return w;
   endfunction

   function automatic int random_free(input int mid, input int full);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         return $urandom_range(0, 2);
      end else if (sel < 8) begin
         return $urandom_range(0, mid);
      end
      return $urandom_range(0, full);
   endfunction

   task automatic send_group(input logic [REQ_DATA_BITS-1:0] word, input issue_outcome_type o);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_groups.push_back(o);
      @(negedge clock);
   endtask

   task automatic report_fail(input string what, input issue_outcome_type exp_o,
                              input issue_outcome_type got_o);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t %s", $realtime, what);
         $display("   expected mask=%b cnt=%0d rob=%0d alu=%0d fpu=%0d lsu=%0d s1=%0d s2=%0d",
                  exp_o.mask, exp_o.count, exp_o.rob_taken, exp_o.alu_pushes,
                  exp_o.fpu_pushes, exp_o.lsu_pushes, exp_o.slot1, exp_o.slot2);
         $display("   actual   mask=%b cnt=%0d rob=%0d alu=%0d fpu=%0d lsu=%0d s1=%0d s2=%0d",
                  got_o.mask, got_o.count, got_o.rob_taken, got_o.alu_pushes,
                  got_o.fpu_pushes, got_o.lsu_pushes, got_o.slot1, got_o.slot2);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      issue_outcome_type got_o;
      issue_outcome_type exp_o;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_o = split_result(rsp_tdata);
         if (pending_groups.size() == 0) begin
            report_fail("result with no request pending", '0, got_o);
         end else begin
            exp_o = pending_groups.pop_front();
            if (got_o != exp_o) begin
               report_fail("result mismatch", exp_o, got_o);
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("[triple_issue_select] ERROR");
      $finish;
   end

   initial begin
      logic [REQ_DATA_BITS-1:0] word;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;

      // Extremes with results that can be read off directly.
      add_row(pack_group(PLAIN_ALU, PLAIN_ALU, PLAIN_ALU, 0, 0, 0, 0), 1'b1,
              outcome(0, 0, 0, 0, 0, 0, SLOT_FROM_FIRST, SLOT_FROM_SECOND));
      add_row(pack_group(FL_ILLEGAL, FL_ILLEGAL, FL_ILLEGAL, 0, 0, 0, 0), 1'b1,
              outcome(7, 3, 0, 0, 0, 0, SLOT_FROM_DECODE, SLOT_FROM_DECODE));
      add_row(pack_group(PLAIN_ALU, PLAIN_ALU, PLAIN_ALU, 15, 15, 15, 63), 1'b1,
              outcome(7, 3, 3, 3, 0, 0, SLOT_FROM_DECODE, SLOT_FROM_DECODE));
      add_row(pack_group(FL_MEM, FL_MEM, FL_MEM, 0, 0, 8, 32), 1'b1,
              outcome(7, 3, 3, 0, 0, 3, SLOT_FROM_DECODE, SLOT_FROM_DECODE));
      add_row(pack_group(FL_FPU, FL_FPU, FL_FPU, 0, 8, 0, 32), 1'b1,
              outcome(7, 3, 3, 0, 3, 0, SLOT_FROM_DECODE, SLOT_FROM_DECODE));
      add_row(pack_group(FL_MEM | FL_FPU, FL_MEM | FL_FPU, FL_MEM | FL_FPU, 0, 8, 1, 32),
              1'b1, outcome(1, 1, 1, 0, 0, 1, SLOT_FROM_SECOND, SLOT_FROM_THIRD));
      add_row(pack_group(PLAIN_ALU, PLAIN_ALU, PLAIN_ALU, 8, 8, 8, 0), 1'b1,
              outcome(0, 0, 0, 0, 0, 0, SLOT_FROM_FIRST, SLOT_FROM_SECOND));
      add_row(pack_group(PLAIN_ALU, PLAIN_ALU, PLAIN_ALU, 8, 8, 8, 1), 1'b1,
              outcome(1, 1, 1, 1, 0, 0, SLOT_FROM_SECOND, SLOT_FROM_THIRD));
      add_row(pack_group('1, '1, '1, 15, 15, 15, 63), 1'b1,
              outcome(7, 3, 0, 0, 0, 0, SLOT_FROM_DECODE, SLOT_FROM_DECODE));

      // Dependency cases behind a stuck oldest instruction.
      add_row(pack_group(mk_instr(PLAIN_ALU, 0, 0, 0, 5), mk_instr(FL_FPU | FL_USE1, 5, 0, 0, 1),
                         mk_instr(FL_FPU, 0, 0, 0, 2), 0, 8, 0, 32), 1'b0, '0);
      add_row(pack_group(mk_instr(PLAIN_ALU, 0, 0, 0, 0), mk_instr(FL_FPU | FL_USE1, 0, 0, 0, 1),
                         mk_instr(FL_FPU | FL_USE2, 0, 0, 0, 2), 0, 8, 0, 32), 1'b0, '0);
      add_row(pack_group(mk_instr(FL_RD_FP, 0, 0, 0, 0),
                         mk_instr(FL_FPU | FL_USE1 | FL_RS1_FP, 0, 0, 0, 1),
                         mk_instr(FL_FPU, 0, 0, 0, 2), 0, 8, 0, 32), 1'b0, '0);
      add_row(pack_group(mk_instr(FL_RD_FP, 0, 0, 0, 7), mk_instr(FL_FPU | FL_USE3, 0, 0, 7, 1),
                         mk_instr(FL_FPU | FL_USE3, 0, 0, 7, 2), 0, 8, 0, 32), 1'b0, '0);
      add_row(pack_group(mk_instr(PLAIN_ALU, 0, 0, 0, 7), mk_instr(FL_FPU | FL_USE3, 0, 0, 7, 1),
                         mk_instr(FL_MEM | FL_USE3, 0, 0, 7, 2), 0, 8, 8, 32), 1'b0, '0);
      add_row(pack_group(mk_instr(PLAIN_ALU, 0, 0, 0, 9), mk_instr(FL_MEM | FL_USE2, 0, 9, 0, 1),
                         mk_instr(FL_MEM | FL_USE1 | FL_RS1_FP, 9, 0, 0, 2), 0, 8, 8, 32),
              1'b0, '0);
      add_row(pack_group(mk_instr(PLAIN_ALU, 0, 0, 0, 4), mk_instr(FL_FPU | FL_USE2, 4, 5, 4, 1),
                         mk_instr(FL_MEM | FL_USE1, 4, 0, 0, 3), 0, 8, 8, 32), 1'b0, '0);
      // The youngest depends on the middle one only, which stalls on a full ALU queue.
      add_row(pack_group(mk_instr(PLAIN_ALU, 0, 0, 0, 1), mk_instr(PLAIN_ALU, 0, 0, 0, 3),
                         mk_instr(FL_FPU | FL_USE2, 0, 3, 0, 2), 1, 8, 8, 32), 1'b0, '0);
      add_row(pack_group(mk_instr(FL_SPARE | FL_HIGH, 1, 2, 3, 4), mk_instr(FL_SPARE, 4, 4, 4, 5),
                         mk_instr(FL_HIGH | FL_USE1, 5, 0, 0, 6), 2, 0, 0, 32), 1'b0, '0);
      add_row(pack_group(mk_instr(FL_MEM, 0, 0, 0, 1), mk_instr(FL_FPU, 0, 0, 0, 2),
                         mk_instr(PLAIN_ALU, 0, 0, 0, 3), 12, 9, 15, 40), 1'b0, '0);
      add_row(pack_group(mk_instr(FL_MEM, 0, 0, 0, 1), mk_instr(FL_ILLEGAL | FL_USE1, 1, 0, 0, 2),
                         mk_instr(FL_FPU, 0, 0, 0, 3), 1, 1, 1, 2), 1'b0, '0);
      add_row(pack_group(mk_instr(FL_FPU, 0, 0, 0, 1), mk_instr(FL_FPU, 0, 0, 0, 2),
                         mk_instr(FL_FPU, 0, 0, 0, 3), 0, 2, 0, 32), 1'b0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         send_group(stim_rows[r].word,
                    stim_rows[r].typed ? stim_rows[r].outcome
                                       : select_issue_group(stim_rows[r].word));
      end

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               send_idle_pct  = 47;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 47;
            end
            3: begin
               send_idle_pct  = 30;
               recv_stall_pct = 30;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            word = pack_group(random_instr(), random_instr(), random_instr(),
                              random_free(8, 15), random_free(8, 15),
                              random_free(8, 15), random_free(32, 63));
            send_group(word, select_issue_group(word));
         end
      end
      req_tvalid <= 1'b0;

      while (pending_groups.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (fail_count == 0 && pending_groups.size() == 0) begin
         $display("[triple_issue_select] OK");
      end else begin
         $display("[triple_issue_select] ERROR");
      end
      $finish;
   end

endmodule
